FILE: rtl/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_W          = 32;
	localparam int TEMP_W         = 16;
	localparam int THR_W          = 17;
	localparam int DIFF_W         = 18;
	localparam int LIM_W          = 24;
	localparam int HALF_LIM_W     = 23;
	localparam int TGT_CC_W       = 15;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 10;

	localparam int MS_PER_MIN      = 60000;
	localparam int MS_PER_HALF_MIN = 30000;
	localparam int CENTI           = 100;

	localparam logic [7:0] TARGET_RST  = 8'd99;
	localparam logic [9:0] UPPER_RST   = 10'd150;
	localparam logic [9:0] LOWER_RST   = 10'd80;
	localparam logic [7:0] TIMEOUT_RST = 8'd10;
	localparam logic [9:0] DROP_RST    = 10'd40;

	typedef enum logic [1:0] {
		KIND_CHECK = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_NO_COOL   = 3'd1,
		ACT_STARTED   = 3'd2,
		ACT_AT_TARGET = 3'd3,
		ACT_COMMAND   = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET   = 3'd0,
		CFG_UPPER    = 3'd1,
		CFG_LOWER    = 3'd2,
		CFG_TIMEOUT  = 3'd3,
		CFG_MIN_DROP = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [NOW_W-1:0]         now_ms;
		logic signed [TEMP_W-1:0] room_temp;
	} cmd_t;

	typedef struct packed {
		logic    fan_on;
		logic    compressor_on;
		action_t action;
	} res_t;

	typedef struct packed {
		logic [LIM_W-1:0]        full_lim;
		logic [HALF_LIM_W-1:0]   half_lim;
		logic signed [THR_W-1:0] start_thr;
		logic signed [THR_W-1:0] stop_thr;
		logic [9:0]              min_drop;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ctc_cfg.sv
`default_nettype none

module ctc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ctc_pkg::CFG_DATA_W-1:0] cfg_data,
	output ctc_pkg::cfg_t                       cfg
);

	logic [7:0] target_q, timeout_q;
	logic [9:0] upper_q, lower_q, drop_q;
	logic [7:0] target_n, timeout_n;
	logic [9:0] upper_n, lower_n, drop_n;
	logic [ctc_pkg::TGT_CC_W-1:0] target_cc;
	ctc_pkg::cfg_t cfg_n, cfg_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_comb begin
		target_n  = target_q;
		upper_n   = upper_q;
		lower_n   = lower_q;
		timeout_n = timeout_q;
		drop_n    = drop_q;
		if (wr) begin
			case (cfg_index)
				ctc_pkg::CFG_TARGET:   target_n  = cfg_data[7:0];
				ctc_pkg::CFG_UPPER:    upper_n   = cfg_data;
				ctc_pkg::CFG_LOWER:    lower_n   = cfg_data;
				ctc_pkg::CFG_TIMEOUT:  timeout_n = cfg_data[7:0];
				ctc_pkg::CFG_MIN_DROP: drop_n    = cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		target_cc       = ctc_pkg::TGT_CC_W'(32'(target_n) * ctc_pkg::CENTI);
		cfg_n.full_lim  = ctc_pkg::LIM_W'(32'(timeout_n) * ctc_pkg::MS_PER_MIN);
		cfg_n.half_lim  = ctc_pkg::HALF_LIM_W'(32'(timeout_n) * ctc_pkg::MS_PER_HALF_MIN);
		cfg_n.start_thr = $signed({2'b00, target_cc}) + $signed({7'b0, upper_n});
		cfg_n.stop_thr  = $signed({2'b00, target_cc}) - $signed({7'b0, lower_n});
		cfg_n.min_drop  = drop_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= ctc_pkg::TARGET_RST;
			upper_q   <= ctc_pkg::UPPER_RST;
			lower_q   <= ctc_pkg::LOWER_RST;
			timeout_q <= ctc_pkg::TIMEOUT_RST;
			drop_q    <= ctc_pkg::DROP_RST;
			cfg_q.full_lim  <= ctc_pkg::LIM_W'(32'(ctc_pkg::TIMEOUT_RST) * ctc_pkg::MS_PER_MIN);
			cfg_q.half_lim  <= ctc_pkg::HALF_LIM_W'(32'(ctc_pkg::TIMEOUT_RST)
				* ctc_pkg::MS_PER_HALF_MIN);
			cfg_q.start_thr <= ctc_pkg::THR_W'(32'(ctc_pkg::TARGET_RST) * ctc_pkg::CENTI
				+ 32'(ctc_pkg::UPPER_RST));
			cfg_q.stop_thr  <= ctc_pkg::THR_W'(32'(ctc_pkg::TARGET_RST) * ctc_pkg::CENTI
				- 32'(ctc_pkg::LOWER_RST));
			cfg_q.min_drop  <= ctc_pkg::DROP_RST;
		end else begin
			target_q  <= target_n;
			upper_q   <= upper_n;
			lower_q   <= lower_n;
			timeout_q <= timeout_n;
			drop_q    <= drop_n;
			cfg_q     <= cfg_n;
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/compressor_thermostat_controller.sv
`default_nettype none
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_stall  ctc_pkg::cmd_t (kind, now_ms, room_temp)
// res      out        res_valid / res_stall  ctc_pkg::res_t (fan_on, compressor_on, action)
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while res is not stalled; a result is registered
// from the command register. The rate is set by the combinational state update from it.
// Reset clears the control state and loads the default settings.
// A stalled result holds the command register, which in turn stalls cmd.
// cfg_ready is always high.

module compressor_thermostat_controller #(
	parameter int TIME_WIDTH = ctc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire ctc_pkg::cmd_t                  cmd,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output ctc_pkg::res_t                       res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ctc_pkg::CFG_DATA_W-1:0] cfg_data
);

	ctc_pkg::cfg_t cfg;
	ctc_pkg::cmd_t cmd_s1;
	logic          cmd_valid_s1;
	ctc_pkg::res_t res_q, res_n;
	logic          res_valid_q;
	logic          accept, advance;

	logic                             system_on_q, fan_q, comp_q, stv_q;
	logic [TIME_WIDTH-1:0]            stamp_q;
	logic signed [ctc_pkg::TEMP_W-1:0] start_temp_q;
	logic                             system_on_n, fan_n, comp_n, stv_n;
	logic [TIME_WIDTH-1:0]            stamp_n;
	logic signed [ctc_pkg::TEMP_W-1:0] start_temp_n;

	logic [TIME_WIDTH-1:0]             now_t, elapsed;
	logic                              full_over, half_over, no_cool;
	logic signed [ctc_pkg::THR_W-1:0]  room17;
	logic signed [ctc_pkg::DIFF_W-1:0] drop_diff;
	logic                              r1, r2, r3;

	ctc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance   = cmd_valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = cmd_valid_s1 && res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		now_t     = TIME_WIDTH'(cmd_s1.now_ms);
		elapsed   = now_t - stamp_q;
		full_over = elapsed > TIME_WIDTH'(cfg.full_lim);
		half_over = elapsed > TIME_WIDTH'(cfg.half_lim);
		room17    = ctc_pkg::THR_W'(cmd_s1.room_temp);
		drop_diff = ctc_pkg::DIFF_W'(start_temp_q) - ctc_pkg::DIFF_W'(cmd_s1.room_temp);
		no_cool   = drop_diff < $signed({8'b0, cfg.min_drop});
		r1 = comp_q && stv_q && full_over && no_cool;
		r2 = !comp_q && (room17 > cfg.start_thr) && full_over;
		r3 = comp_q && (room17 <= cfg.stop_thr) && half_over;
	end

	always_comb begin
		system_on_n  = system_on_q;
		fan_n        = fan_q;
		comp_n       = comp_q;
		stv_n        = stv_q;
		stamp_n      = stamp_q;
		start_temp_n = start_temp_q;
		res_n.action = ctc_pkg::ACT_NONE;
		case (cmd_s1.kind)
			ctc_pkg::KIND_START: begin
				fan_n        = 1'b1;
				stamp_n      = now_t;
				system_on_n  = 1'b1;
				res_n.action = ctc_pkg::ACT_COMMAND;
			end
			ctc_pkg::KIND_STOP: begin
				comp_n       = 1'b0;
				fan_n        = 1'b0;
				stamp_n      = '0;
				system_on_n  = 1'b0;
				res_n.action = ctc_pkg::ACT_COMMAND;
			end
			ctc_pkg::KIND_CHECK: begin
				if (system_on_q) begin
					if (r1) begin
						comp_n       = 1'b0;
						stamp_n      = now_t;
						stv_n        = 1'b0;
						res_n.action = ctc_pkg::ACT_NO_COOL;
					end else if (r2) begin
						comp_n       = 1'b1;
						stamp_n      = now_t;
						start_temp_n = cmd_s1.room_temp;
						stv_n        = 1'b1;
						res_n.action = ctc_pkg::ACT_STARTED;
					end else if (r3) begin
						comp_n       = 1'b0;
						stamp_n      = now_t;
						stv_n        = 1'b0;
						res_n.action = ctc_pkg::ACT_AT_TARGET;
					end
				end
			end
			default: ;
		endcase
		res_n.fan_on        = fan_n;
		res_n.compressor_on = comp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
			system_on_q  <= 1'b0;
			fan_q        <= 1'b0;
			comp_q       <= 1'b0;
			stv_q        <= 1'b0;
			stamp_q      <= '0;
			start_temp_q <= '0;
		end else begin
			if (accept) begin
				cmd_valid_s1 <= 1'b1;
			end else if (advance) begin
				cmd_valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q  <= 1'b1;
				system_on_q  <= system_on_n;
				fan_q        <= fan_n;
				comp_q       <= comp_n;
				stv_q        <= stv_n;
				stamp_q      <= stamp_n;
				start_temp_q <= start_temp_n;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_comp_needs_system: assert property (@(posedge clk) disable iff (!arst_n)
		comp_q |-> system_on_q)
		else $error("compressor running while system is off");

	a_fan_tracks_system: assert property (@(posedge clk) disable iff (!arst_n)
		fan_q == system_on_q)
		else $error("fan level differs from system state");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |=> cmd_valid_s1 && $stable(cmd_s1))
		else $error("held request lost while result stalled");

	a_started_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.action == ctc_pkg::ACT_STARTED |-> res.compressor_on && res.fan_on)
		else $error("start result without compressor running");

	a_stop_levels: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1.kind == ctc_pkg::KIND_STOP |=> !comp_q && !system_on_q)
		else $error("stop request left the system running");
`endif

endmodule

`default_nettype wire

FILE: test/compressor_thermostat_controller_tb.sv
`timescale 1ns / 100ps

module compressor_thermostat_controller_tb;

	import ctc_pkg::*;

	localparam logic [1:0]           KIND_UNUSED    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
	localparam int                   HOLD_CYCLES    = 80;
	localparam int                   QUIET_LIMIT    = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// thermostat settings and control state as the block should hold them
	logic [7:0]  th_target  = TARGET_RST;
	logic [9:0]  th_upper   = UPPER_RST;
	logic [9:0]  th_lower   = LOWER_RST;
	logic [7:0]  th_timeout = TIMEOUT_RST;
	logic [9:0]  th_drop    = DROP_RST;
	logic        sys_on = 1'b0;
	logic        fan_st = 1'b0;
	logic        comp_st = 1'b0;
	logic [31:0] sw_stamp = '0;
	int          st_temp = 0;
	logic        st_valid = 1'b0;

	cmd_t        cmd_pending[$];
	res_t        res_due[$];
	int          n_issued = 0;
	int          n_taken = 0;
	int          n_err = 0;
	int          quiet = 0;
	int          send_idle_pct = 26;
	int          recv_idle_pct = 26;
	logic        cmd_fire = 1'b0;
	logic        hold_go = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;

	logic [31:0] gen_t = '0;
	logic        gen_on = 1'b0;
	int          gen_room = 0;

	compressor_thermostat_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic res_t thermo_step(cmd_t c);
		res_t        r;
		logic [31:0] since;
		logic [31:0] full_ms;
		logic [31:0] half_ms;
		int          room;
		int          tgt_cc;
		int          up;
		int          lo;
		int          dr;
		room    = c.room_temp;
		since   = c.now_ms - sw_stamp;
		full_ms = MS_PER_MIN * th_timeout;
		half_ms = MS_PER_HALF_MIN * th_timeout;
		tgt_cc  = CENTI * th_target;
		up      = th_upper;
		lo      = th_lower;
		dr      = th_drop;
		r.action = ACT_NONE;
		case (c.kind)
		KIND_START: begin
			fan_st   = 1'b1;
			sw_stamp = c.now_ms;
			sys_on   = 1'b1;
			r.action = ACT_COMMAND;
		end
		KIND_STOP: begin
			comp_st  = 1'b0;
			fan_st   = 1'b0;
			sw_stamp = '0;
			sys_on   = 1'b0;
			r.action = ACT_COMMAND;
		end
		KIND_CHECK: begin
			if (sys_on) begin
				if (comp_st && st_valid && since > full_ms && st_temp - room < dr) begin
					comp_st  = 1'b0;
					sw_stamp = c.now_ms;
					st_valid = 1'b0;
					r.action = ACT_NO_COOL;
				end else if (!comp_st && room > tgt_cc + up && since > full_ms) begin
					comp_st  = 1'b1;
					sw_stamp = c.now_ms;
					st_temp  = room;
					st_valid = 1'b1;
					r.action = ACT_STARTED;
				end else if (comp_st && room <= tgt_cc - lo && since > half_ms) begin
					comp_st  = 1'b0;
					sw_stamp = c.now_ms;
					st_valid = 1'b0;
					r.action = ACT_AT_TARGET;
				end
			end
		end
		default: ;
		endcase
		r.fan_on        = fan_st;
		r.compressor_on = comp_st;
		return r;
	endfunction

	function automatic cmd_t gen_cmd();
		cmd_t c;
		int   r;
		int   v;
		int   step;
		int   full_ms;
		int   half_ms;
		int   tgt_cc;
		int   up;
		int   lo;
		int   dr;
		full_ms = MS_PER_MIN * th_timeout;
		half_ms = MS_PER_HALF_MIN * th_timeout;
		tgt_cc  = CENTI * th_target;
		up      = th_upper;
		lo      = th_lower;
		dr      = th_drop;
		r = $urandom_range(99);
		if (!gen_on) begin
			if (r < 85)
				c.kind = KIND_START;
			else if (r < 92)
				c.kind = KIND_UNUSED;
			else if (r < 96)
				c.kind = KIND_STOP;
			else
				c.kind = KIND_CHECK;
		end else begin
			if (r < 5)
				c.kind = KIND_STOP;
			else if (r < 9)
				c.kind = KIND_START;
			else if (r < 12)
				c.kind = KIND_UNUSED;
			else
				c.kind = KIND_CHECK;
		end
		if (c.kind == KIND_START)
			gen_on = 1'b1;
		else if (c.kind == KIND_STOP)
			gen_on = 1'b0;

		case ($urandom_range(7))
		0: step = 0;
		1: step = $urandom_range(1000);
		2: step = half_ms + int'($urandom_range(2)) - 1;
		3: step = full_ms + int'($urandom_range(2)) - 1;
		4: step = $urandom_range(full_ms * 2 + 2);
		5: begin
			gen_t = $urandom;
			step  = 0;
		end
		default: step = $urandom_range(full_ms + full_ms / 2 + 2);
		endcase
		if (step < 0)
			step = 0;
		gen_t    = gen_t + step;
		c.now_ms = gen_t;

		case ($urandom_range(9))
		0: v = tgt_cc + up + int'($urandom_range(2)) - 1;
		1: v = tgt_cc + up + int'($urandom_range(300));
		2: v = tgt_cc - lo + int'($urandom_range(2)) - 1;
		3: v = tgt_cc - lo - int'($urandom_range(300));
		4: v = gen_room - dr + int'($urandom_range(2)) - 1;
		5: v = 32767;
		6: v = -32768;
		7: v = int'($urandom_range(65535)) - 32768;
		default: v = tgt_cc + int'($urandom_range(800)) - 400;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		if (v > tgt_cc + up)
			gen_room = v;
		c.room_temp = v[15:0];
		return c;
	endfunction

	task automatic push_cmd(input logic [1:0] kind, input logic [31:0] now, input int room);
		cmd_t c;
		c.kind      = kind;
		c.now_ms    = now;
		c.room_temp = room[15:0];
		cmd_pending.push_back(c);
		n_issued++;
	endtask

	task automatic wait_drain();
		do @(negedge clk); while (n_taken != n_issued || res_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_TARGET:   th_target  = val[7:0];
		CFG_UPPER:    th_upper   = val;
		CFG_LOWER:    th_lower   = val;
		CFG_TIMEOUT:  th_timeout = val[7:0];
		CFG_MIN_DROP: th_drop    = val;
		default: ;
		endcase
	endtask

	task automatic set_all(input logic [CFG_DATA_W-1:0] tgt, input logic [CFG_DATA_W-1:0] up,
			input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] tmo,
			input logic [CFG_DATA_W-1:0] dr);
		set_reg(CFG_TARGET, tgt);
		set_reg(CFG_UPPER, up);
		set_reg(CFG_LOWER, lo);
		set_reg(CFG_TIMEOUT, tmo);
		set_reg(CFG_MIN_DROP, dr);
		set_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(1023)));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input int idle_pct, input bit hold);
		cmd_t c;
		send_idle_pct = idle_pct;
		recv_idle_pct = idle_pct;
		for (int i = 0; i < n_items; i++) begin
			c = gen_cmd();
			push_cmd(c.kind, c.now_ms, c.room_temp);
		end
		if (hold)
			hold_go = ~hold_go;
		wait_drain();
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_fire) begin
			if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd       <= cmd_pending.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result back-pressure; hold off for a long stretch on request
	always @(negedge clk) begin
		if (hold_seen != hold_go) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			cmd_fire <= 1'b0;
		end else begin
			cmd_fire <= cmd_valid && !cmd_stall;
			if (cmd_valid && !cmd_stall) begin
				res_due.push_back(thermo_step(cmd));
				n_taken++;
			end
			if (res_valid && !res_stall) begin
				if (res_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, res);
					n_err++;
				end else begin
					want = res_due.pop_front();
					if (res.fan_on !== want.fan_on) begin
						$display("%0t: fan_on expected %0b actual %0b", $time, want.fan_on,
							res.fan_on);
						n_err++;
					end
					if (res.compressor_on !== want.compressor_on) begin
						$display("%0t: compressor_on expected %0b actual %0b", $time,
							want.compressor_on, res.compressor_on);
						n_err++;
					end
					if (res.action !== want.action) begin
						$display("%0t: action expected %0d actual %0d", $time, want.action,
							res.action);
						n_err++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [31:0] t;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: full timeout 600000 ms, half 300000 ms, start above 10050,
		// stop at or below 9820
		t = 32'd5000;
		push_cmd(KIND_CHECK, t, 10000);
		push_cmd(KIND_UNUSED, t, 32767);
		push_cmd(KIND_START, t, 0);
		push_cmd(KIND_CHECK, t + 32'd600001, 10050);
		push_cmd(KIND_CHECK, t + 32'd600000, 10051);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 10051);
		t = t + 32'd10;
		push_cmd(KIND_START, t, 10051);
		push_cmd(KIND_CHECK, t + 32'd300000, 9820);
		t = t + 32'd300001;
		push_cmd(KIND_CHECK, t, 9820);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 32767);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 32728);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 32767);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 32727);
		push_cmd(KIND_STOP, t, 0);
		push_cmd(KIND_CHECK, t + 32'd700000, -32768);
		t = 32'hFFFF_FFF0;
		push_cmd(KIND_START, t, 0);
		t = t + 32'd600001;
		push_cmd(KIND_CHECK, t, 32767);
		t = t + 32'd300001;
		push_cmd(KIND_CHECK, t, -32768);
		push_cmd(KIND_STOP, t, 0);
		wait_drain();

		run_phase(80, 26, 1'b0);
		set_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		run_phase(80, 26, 1'b1);
		set_all(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
		run_phase(80, 26, 1'b0);
		set_all(10'd25, 10'd100, 10'd50, 10'd1, 10'd30);
		run_phase(80, 0, 1'b0);
		repeat (4) begin
			set_all(CFG_DATA_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(1023)),
				CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(3)),
				CFG_DATA_W'($urandom_range(1023)));
			run_phase(80, 26, 1'b0);
		end

		repeat (6) @(posedge clk);
		if (n_err == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
